### hw/rtl/ivm_pkg.sv
// Shared definitions for the interval value map: operation codes and the
// control bundle broadcast to every table cell. No dependencies.
`default_nettype none

package ivm_pkg;

    localparam logic [1:0] OP_ASSIGN = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CLEAR  = 2'd2;

    // pop: every cell takes its right neighbor; push: the tail slot takes new data
    typedef struct packed {
        logic pop;
        logic push;
    } t_cell_ctl;

endpackage

`default_nettype wire

### hw/rtl/interval_value_map.sv
// Interval value map top level: sequencer plus a row of ivm_cell slots.
// Depends on ivm_pkg and ivm_cell.
// A lookup scans the row once; an assign scans it and then rebuilds it in a
// second pass; a clear reloads entry 0; an empty assign or unused code goes
// straight to the result. Each pass moves the cell row one slot per cycle.
// One item is in work at a time; a new beat is taken while the previous
// result still waits. Reset (synchronous, active low) empties the row; the
// S_INIT state then loads entry 0 with key 0 and the default value.
`default_nettype none

module interval_value_map #(
    parameter int TABLE_ENTRIES = 64,
    parameter int KEY_BITS      = 32,
    parameter int VALUE_BITS    = 8,
    localparam int CNT_BITS     = $clog2(TABLE_ENTRIES + 1)
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    // configuration channel: default value
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire [VALUE_BITS-1:0]  i_cfg_data,
    // input item channel
    input  wire                   i_in_valid,
    output logic                  o_in_ready,
    input  wire [1:0]             i_operation,
    input  wire [KEY_BITS-1:0]    i_key_begin,
    input  wire [KEY_BITS-1:0]    i_key_end,
    input  wire [VALUE_BITS-1:0]  i_assign_value,
    // result channel
    output logic                  o_out_valid,
    input  wire                   i_out_ready,
    output logic [VALUE_BITS-1:0] o_result_value,
    output logic [CNT_BITS-1:0]   o_entry_count,
    output logic                  o_full_error
);
    import ivm_pkg::*;

    // two spare slots absorb the inserted boundaries before the covered
    // ones have been popped
    localparam int CELLS    = TABLE_ENTRIES + 2;
    localparam int OCC_BITS = $clog2(CELLS + 1);
    localparam logic [OCC_BITS:0] LIMIT = (OCC_BITS+1)'(TABLE_ENTRIES);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_SCAN, S_EVAL, S_CLR, S_CLT, S_CB, S_CE, S_CGT, S_FIN
    } t_state;

    t_state                r_state;
    logic [1:0]            r_op;
    logic [KEY_BITS-1:0]   r_b, r_e;
    logic [VALUE_BITS-1:0] r_v, r_dflt;
    logic [OCC_BITS-1:0]   r_occ, r_rem, r_lt_cnt, r_gt_cnt;
    logic [VALUE_BITS-1:0] r_last_lt, r_end_val, r_look, r_prev;
    logic                  r_pushed, r_full;
    logic                  r_o_valid, r_o_full;
    logic [VALUE_BITS-1:0] r_o_value;
    logic [CNT_BITS-1:0]   r_o_count;

    t_cell_ctl             w_ctl;
    logic [KEY_BITS-1:0]   w_pkey;
    logic [VALUE_BITS-1:0] w_pval;
    logic [KEY_BITS-1:0]   w_key [CELLS];
    logic [VALUE_BITS-1:0] w_val [CELLS];
    logic [KEY_BITS-1:0]   w_hkey;
    logic [VALUE_BITS-1:0] w_hval;
    logic                  w_lt_go, w_pb, w_pe;
    logic [OCC_BITS:0]     w_cnt;

    // the row of table slots; each pop hands every slot its right neighbor
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        logic [KEY_BITS-1:0]   w_nk;
        logic [VALUE_BITS-1:0] w_nv;
        if (g == CELLS - 1) begin : g_tail
            assign w_nk = w_pkey;
            assign w_nv = w_pval;
        end else begin : g_mid
            assign w_nk = w_key[g+1];
            assign w_nv = w_val[g+1];
        end
        ivm_cell #(
            .IDX(g), .KEY_BITS(KEY_BITS), .VAL_BITS(VALUE_BITS), .OCC_BITS(OCC_BITS)
        ) u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occ      (r_occ),
            .i_next_key (w_nk),
            .i_next_val (w_nv),
            .i_push_key (w_pkey),
            .i_push_val (w_pval),
            .o_key      (w_key[g]),
            .o_val      (w_val[g])
        );
    end

    assign w_hkey  = w_key[0];
    assign w_hval  = w_val[0];
    assign w_lt_go = (r_rem != '0) && (w_hkey < r_b);

    // merged size: kept low part, new start, new end, kept high part.
    // The start boundary merges into an equal left neighbor; after it the
    // last value is always the assigned one, so the end merges if equal.
    assign w_pb  = (r_lt_cnt == '0) || (r_last_lt != r_v);
    assign w_pe  = (r_v != r_end_val);
    assign w_cnt = {1'b0, r_lt_cnt} + {1'b0, r_gt_cnt}
                 + {{OCC_BITS{1'b0}}, w_pb} + {{OCC_BITS{1'b0}}, w_pe};

    always_comb begin
        w_ctl  = '0;
        w_pkey = w_hkey;
        w_pval = w_hval;
        unique case (r_state) inside
            S_INIT, S_CLR: begin
                w_ctl.push = 1'b1;
                w_pkey     = '0;
                w_pval     = r_dflt;
            end
            S_SCAN: begin
                // rotate: the head goes back in at the tail
                w_ctl.pop  = (r_rem != '0);
                w_ctl.push = (r_rem != '0);
            end
            S_CLT: begin
                w_ctl.pop  = w_lt_go;
                w_ctl.push = w_lt_go && !(r_pushed && (r_prev == w_hval));
            end
            S_CB: begin
                w_ctl.push = !(r_pushed && (r_prev == r_v));
                w_pkey     = r_b;
                w_pval     = r_v;
            end
            S_CE: begin
                w_ctl.push = w_pe;
                w_pkey     = r_e;
                w_pval     = r_end_val;
            end
            S_CGT: begin
                // drop covered boundaries, keep those past the end
                w_ctl.pop  = (r_rem != '0);
                w_ctl.push = (r_rem != '0) && (w_hkey > r_e);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_occ     <= '0;
            r_dflt    <= '0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_dflt <= i_cfg_data;
            end
            if (r_o_valid && i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            r_occ <= r_occ + {{(OCC_BITS-1){1'b0}}, w_ctl.push}
                           - {{(OCC_BITS-1){1'b0}}, w_ctl.pop};

            unique case (r_state)
                S_INIT: r_state <= S_IDLE;
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op      <= i_operation;
                        r_b       <= i_key_begin;
                        r_e       <= i_key_end;
                        r_v       <= i_assign_value;
                        r_full    <= 1'b0;
                        r_rem     <= r_occ;
                        r_lt_cnt  <= '0;
                        r_gt_cnt  <= '0;
                        r_look    <= '0;
                        r_last_lt <= '0;
                        r_end_val <= '0;
                        if (i_operation == OP_ASSIGN) begin
                            r_state <= (i_key_begin < i_key_end) ? S_SCAN : S_FIN;
                        end else if (i_operation == OP_LOOKUP) begin
                            r_state <= S_SCAN;
                        end else if (i_operation == OP_CLEAR) begin
                            r_occ   <= '0;
                            r_state <= S_CLR;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_rem != '0) begin
                        r_rem <= r_rem - 1'b1;
                        if (w_hkey < r_b) begin
                            r_lt_cnt  <= r_lt_cnt + 1'b1;
                            r_last_lt <= w_hval;
                        end
                        if (w_hkey <= r_b) r_look <= w_hval;
                        if (w_hkey <= r_e) r_end_val <= w_hval;
                        if (w_hkey > r_e)  r_gt_cnt <= r_gt_cnt + 1'b1;
                    end else begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_op == OP_LOOKUP) begin
                        r_state <= S_FIN;
                    end else if (w_cnt > LIMIT) begin
                        // refuse: table left as it is
                        r_full  <= 1'b1;
                        r_state <= S_FIN;
                    end else begin
                        r_rem    <= r_occ;
                        r_pushed <= 1'b0;
                        r_state  <= S_CLT;
                    end
                end
                S_CLR: r_state <= S_FIN;
                S_CLT: begin
                    if (w_lt_go) begin
                        r_rem <= r_rem - 1'b1;
                        if (w_ctl.push) begin
                            r_prev   <= w_hval;
                            r_pushed <= 1'b1;
                        end
                    end else begin
                        r_state <= S_CB;
                    end
                end
                S_CB: r_state <= S_CE;
                S_CE: r_state <= S_CGT;
                S_CGT: begin
                    if (r_rem != '0) begin
                        r_rem <= r_rem - 1'b1;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // hold the result until the output register is free
                    if (!r_o_valid || i_out_ready) begin
                        r_o_valid <= 1'b1;
                        r_o_value <= (r_op == OP_LOOKUP) ? r_look : '0;
                        r_o_count <= r_occ[CNT_BITS-1:0];
                        r_o_full  <= r_full;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_cfg_ready    = 1'b1;
    assign o_in_ready     = (r_state == S_IDLE);
    assign o_out_valid    = r_o_valid;
    assign o_result_value = r_o_value;
    assign o_entry_count  = r_o_count;
    assign o_full_error   = r_o_full;

endmodule

`default_nettype wire

### hw/rtl/ivm_cell.sv
// One slot of the boundary table shift queue: holds one key/value boundary.
// Depends on ivm_pkg for the control bundle.
`default_nettype none

module ivm_cell #(
    parameter int IDX      = 0,
    parameter int KEY_BITS = 32,
    parameter int VAL_BITS = 8,
    parameter int OCC_BITS = 7
) (
    input  wire                    i_clk,
    input  ivm_pkg::t_cell_ctl     i_ctl,
    input  wire [OCC_BITS-1:0]     i_occ,
    input  wire [KEY_BITS-1:0]     i_next_key,
    input  wire [VAL_BITS-1:0]     i_next_val,
    input  wire [KEY_BITS-1:0]     i_push_key,
    input  wire [VAL_BITS-1:0]     i_push_val,
    output logic [KEY_BITS-1:0]    o_key,
    output logic [VAL_BITS-1:0]    o_val
);
    import ivm_pkg::*;

    localparam logic [OCC_BITS:0] MY_IDX = (OCC_BITS+1)'(IDX);

    logic [KEY_BITS-1:0] r_key;
    logic [VAL_BITS-1:0] r_val;
    logic                w_take_push;

    // after a pop the tail slot moves down by one
    assign w_take_push = i_ctl.push &&
        ((MY_IDX + {{OCC_BITS{1'b0}}, i_ctl.pop}) == {1'b0, i_occ});

    always_ff @(posedge i_clk) begin
        if (w_take_push) begin
            r_key <= i_push_key;
            r_val <= i_push_val;
        end else if (i_ctl.pop) begin
            r_key <= i_next_key;
            r_val <= i_next_val;
        end
    end

    assign o_key = r_key;
    assign o_val = r_val;

endmodule

`default_nettype wire

### hw/rtl/ivm_check.sv
// Port-level checks for interval_value_map, bound to the top level.
// Depends only on the top level's ports.
`default_nettype none

module ivm_check #(
    parameter int TABLE_ENTRIES = 64,
    parameter int VALUE_BITS    = 8,
    parameter int CNT_BITS      = 7
) (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  i_in_valid,
    input wire                  o_in_ready,
    input wire                  o_out_valid,
    input wire                  i_out_ready,
    input wire [VALUE_BITS-1:0] o_result_value,
    input wire [CNT_BITS-1:0]   o_entry_count,
    input wire                  o_full_error
);

    // a stalled result beat holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_result_value)
            && $stable(o_entry_count) && $stable(o_full_error))
        else $error("result beat changed while stalled");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_entry_count != '0)
            && (o_entry_count <= CNT_BITS'(TABLE_ENTRIES)))
        else $error("entry count out of range");

    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_full_error |-> o_result_value == '0)
        else $error("refused assign carries a value");

    // an accepted beat never yields a result in the very next cycle
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && !o_out_valid |=> !o_out_valid)
        else $error("result appeared too early");

endmodule

bind interval_value_map ivm_check #(
    .TABLE_ENTRIES(TABLE_ENTRIES),
    .VALUE_BITS   (VALUE_BITS),
    .CNT_BITS     (CNT_BITS)
) u_ivm_check (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_result_value (o_result_value),
    .o_entry_count  (o_entry_count),
    .o_full_error   (o_full_error)
);

`default_nettype wire

### bench/tb_interval_value_map.sv
// Self-checking bench for interval_value_map: drives assign, lookup, clear and unused-code beats,
// predicts each result with a sorted boundary table of its own and checks every result beat.
// Depends on ivm_pkg and the interval_value_map RTL.
`timescale 1ns / 1ps

module tb_interval_value_map;
    import ivm_pkg::*;

    localparam int ENTRIES    = 64;
    localparam int CYCLE_CAP  = 3000000;
    localparam int DRAIN_WAIT = 200;
    localparam logic [1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic [7:0] value;
        logic [6:0] count;
        logic       full;
    } t_map_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [1:0]  i_operation;
    logic [31:0] i_key_begin;
    logic [31:0] i_key_end;
    logic [7:0]  i_assign_value;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_result_value;
    logic [6:0]  o_entry_count;
    logic        o_full_error;

    interval_value_map u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_operation(i_operation),
        .i_key_begin(i_key_begin), .i_key_end(i_key_end), .i_assign_value(i_assign_value),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .o_result_value(o_result_value), .o_entry_count(o_entry_count),
        .o_full_error(o_full_error)
    );

    // Shadow copy of the boundary table
    logic [31:0] shadow_key[ENTRIES];
    logic [7:0]  shadow_val[ENTRIES];
    int          shadow_used;
    logic [7:0]  shadow_default;

    t_map_result pending_results[$];
    int          error_count;
    int          cycle_count;
    int          stall_left;
    bit          stall_enable;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Bound the run; drop straight to fail on a hang
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        error_count++;
    endtask

    function automatic void table_reset();
        for (int i = 0; i < ENTRIES; i++) begin
            shadow_key[i] = '0;
            shadow_val[i] = '0;
        end
        shadow_val[0] = shadow_default;
        shadow_used   = 1;
    endfunction

    function automatic logic [7:0] value_at(input logic [31:0] key);
        logic [7:0] v;
        v = shadow_val[0];
        for (int i = 1; i < shadow_used; i++) begin
            if (shadow_key[i] <= key) v = shadow_val[i];
            else break;
        end
        return v;
    endfunction

    // Merge [b, e) := v into the shadow table; return 1 if it will not fit.
    function automatic bit merge_interval(input logic [31:0] b, input logic [31:0] e,
                                          input logic [7:0] v);
        logic [31:0] mk[ENTRIES+2];
        logic [7:0]  mv[ENTRIES+2];
        logic [7:0]  tail_val;
        int          n;
        if (b >= e) return 1'b0;
        tail_val = value_at(e);
        n = 0;
        for (int i = 0; i < shadow_used; i++)
            if (shadow_key[i] < b && (n == 0 || mv[n-1] != shadow_val[i])) begin
                mk[n] = shadow_key[i]; mv[n] = shadow_val[i]; n++;
            end
        if (n == 0 || mv[n-1] != v) begin mk[n] = b; mv[n] = v; n++; end
        if (mv[n-1] != tail_val) begin mk[n] = e; mv[n] = tail_val; n++; end
        for (int i = 0; i < shadow_used; i++)
            if (shadow_key[i] > e && mv[n-1] != shadow_val[i] && n < ENTRIES + 2) begin
                mk[n] = shadow_key[i]; mv[n] = shadow_val[i]; n++;
            end
        if (n > ENTRIES) return 1'b1;
        for (int i = 0; i < n; i++) begin
            shadow_key[i] = mk[i];
            shadow_val[i] = mv[i];
        end
        shadow_used = n;
        return 1'b0;
    endfunction

    function automatic t_map_result predict_step(input logic [1:0] op, input logic [31:0] b,
                                                 input logic [31:0] e, input logic [7:0] v);
        t_map_result r;
        r = '0;
        case (op)
            OP_ASSIGN: r.full = merge_interval(b, e, v);
            OP_LOOKUP: r.value = value_at(b);
            OP_CLEAR:  table_reset();
            default: ;
        endcase
        r.count = shadow_used[6:0];
        return r;
    endfunction

    function automatic int short_gap();
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
        return 0;
    endfunction

    // Send one beat; record its expected result at acceptance. Valid stays
    // high into the next beat when no gap follows.
    task automatic send_item(input logic [1:0] op, input logic [31:0] b,
                             input logic [31:0] e, input logic [7:0] v);
        int gap;
        gap = stall_enable ? short_gap() : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= op;
        i_key_begin    <= b;
        i_key_end      <= e;
        i_assign_value <= v;
        do @(posedge i_clk); while (!o_in_ready);
        pending_results.push_back(predict_step(op, b, e, v));
        @(negedge i_clk);
    endtask

    // Randomize result-side backpressure at each falling edge, with rare long stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left  <= 0;
        end else if (!stall_enable) begin
            i_out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if ($urandom_range(0, 49) == 0) begin
            stall_left  <= $urandom_range(10, 40);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Check every result beat against the oldest expectation
    always @(posedge i_clk) begin
        t_map_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = pending_results.pop_front();
                if (o_result_value !== want.value)
                    report_mismatch("result_value", o_result_value, want.value);
                if (o_entry_count !== want.count)
                    report_mismatch("entry_count", o_entry_count, want.count);
                if (o_full_error !== want.full)
                    report_mismatch("full_error", o_full_error, want.full);
            end
        end
    end

    // Hold until idle, then write the default value register
    task automatic write_default(input logic [7:0] d);
        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= d;
        do @(posedge i_clk); while (!o_cfg_ready);
        shadow_default = d;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [31:0] rand_key();
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 15);
            1: return 32'hFFFF_FFF0 + $urandom_range(0, 15);
            default: return $urandom;
        endcase
    endfunction

    task automatic test_directed();
        write_default(8'hFF);
        send_item(OP_CLEAR, 0, 0, 0);
        send_item(OP_LOOKUP, 32'hFFFF_FFFF, 0, 0);
        send_item(OP_ASSIGN, 0, 32'hFFFF_FFFF, 8'h00);
        send_item(OP_LOOKUP, 32'hFFFF_FFFE, 0, 0);
        send_item(OP_LOOKUP, 32'hFFFF_FFFF, 0, 0);
        send_item(OP_ASSIGN, 10, 10, 8'h55);          // empty interval
        send_item(OP_ASSIGN, 20, 10, 8'h55);          // reversed interval
        send_item(OP_ASSIGN, 10, 20, 8'hAA);
        send_item(OP_ASSIGN, 15, 30, 8'hAA);          // merges with neighbor
        send_item(OP_LOOKUP, 9, 0, 0);
        send_item(OP_LOOKUP, 29, 0, 0);
        send_item(OP_ASSIGN, 0, 32'hFFFF_FFFF, 8'h00);
        send_item(OP_SPARE, 5, 6, 8'h11);             // unused code
        send_item(OP_LOOKUP, 0, 32'hFFFF_FFFF, 8'hFF);
        // Fill the table until assigns are refused
        for (int i = 0; i < 36; i++)
            send_item(OP_ASSIGN, 100 + 4 * i, 102 + 4 * i, 8'h01 + i[7:0]);
        send_item(OP_LOOKUP, 101, 0, 0);
        send_item(OP_CLEAR, 0, 0, 0);
    endtask

    task automatic test_random(input int count);
        logic [31:0] b, e;
        for (int i = 0; i < count; i++) begin
            b = rand_key();
            e = ($urandom_range(0, 9) == 0) ? rand_key() : b + $urandom_range(1, 300);
            case ($urandom_range(0, 19))
                0:        send_item(OP_CLEAR, b, e, 8'($urandom));
                1:        send_item(OP_SPARE, b, e, 8'($urandom));
                2, 3, 4, 5, 6, 7, 8: send_item(OP_LOOKUP, b, $urandom, 8'($urandom));
                default:  send_item(OP_ASSIGN, b, e,
                                    $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'd7);
            endcase
        end
    endtask

    initial begin
        error_count    = 0;
        cycle_count    = 0;
        stall_left     = 0;
        stall_enable   = 1'b0;
        shadow_default = 8'h00;
        i_rst_n        = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        i_in_valid     = 1'b0;
        i_operation    = OP_ASSIGN;
        i_key_begin    = '0;
        i_key_end      = '0;
        i_assign_value = '0;
        i_out_ready    = 1'b0;
        table_reset();
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        stall_enable = 1'b1;
        write_default(8'h00);
        send_item(OP_CLEAR, 0, 0, 0);
        test_random(500);
        write_default(8'($urandom));
        send_item(OP_CLEAR, 0, 0, 0);
        stall_enable = 1'b0;
        test_random(300);
        stall_enable = 1'b1;
        write_default(8'hFF);
        send_item(OP_CLEAR, 0, 0, 0);
        test_random(700);

        i_in_valid <= 1'b0;
        wait (pending_results.size() == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

### files.f
hw/rtl/ivm_pkg.sv
hw/rtl/ivm_cell.sv
hw/rtl/interval_value_map.sv
hw/rtl/ivm_check.sv
bench/tb_interval_value_map.sv
